// ===== design/ats_pkg.sv =====
// shared types and constants for the adaptive trace sampler
package ats_pkg;

    localparam int SLOT_COUNT_DEF  = 1024;
    localparam int ENTER_PCT_DEF   = 75;
    localparam int EXIT_PCT_DEF    = 50;
    localparam int TIME_WIDTH_DEF  = 48;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int OCC_W      = 11;
    localparam int CNT_W      = 32;
    localparam int RATIO_W    = 16;

    localparam logic [31:0] LCG_MUL = 32'd1103515245;
    localparam logic [31:0] LCG_ADD = 32'd12345;
    localparam logic [31:0] SEED_RST = 32'd12345;

    typedef enum logic [1:0] {
        CMD_SAMPLE  = 2'd0,
        CMD_ENQUEUE = 2'd1,
        CMD_DEQUEUE = 2'd2,
        CMD_UPDATE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_NORMAL_SAMPLE   = 3'd0,
        REG_NORMAL_DROP     = 3'd1,
        REG_PRESSURE_SAMPLE = 3'd2,
        REG_PRESSURE_DROP   = 3'd3,
        REG_DROP_THRESHOLD  = 3'd4,
        REG_DROP_WINDOW     = 3'd5,
        REG_QUIET_CLEAR     = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic admitted;
        logic enqueued;
        logic dequeued;
        logic pressure_mode;
        logic fill_flag;
        logic drop_flag;
        logic [OCC_W-1:0] occupancy;
        logic [CNT_W-1:0] drop_total;
        logic [CNT_W-1:0] rejected_total;
    } result_t;

endpackage

// ===== design/ats_stream_if.sv =====
// valid/ready channel carrying a generic payload
interface ats_stream_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/ats_front.sv =====
// front: accepts events into a short queue
module ats_front #(
    parameter int TW = ats_pkg::TIME_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [1:0]     in_cmd,
    input  logic [TW-1:0]  in_time,
    output logic           q_valid,
    input  logic           q_pop,
    output logic [1:0]     q_cmd,
    output logic [TW-1:0]  q_time
);
    // two-entry event queue
    logic [1:0]    cmd_reg [2];
    logic [TW-1:0] time_reg [2];
    logic          rd_reg, rd_next, wr_reg, wr_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          push;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = cmd_reg[rd_reg];
    assign q_time   = time_reg[rd_reg];

    always_comb
    begin
        rd_next  = rd_reg ^ q_pop;
        wr_next  = wr_reg ^ push;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cmd_reg[wr_reg]  <= in_cmd;
            time_reg[wr_reg] <= in_time;
        end
    end
endmodule

// ===== design/ats_back.sv =====
// back: executes events, with a bit-serial modulo for sampling
module ats_back #(
    parameter int QD = ats_pkg::SLOT_COUNT_DEF,
    parameter int EP = ats_pkg::ENTER_PCT_DEF,
    parameter int XP = ats_pkg::EXIT_PCT_DEF,
    parameter int TW = ats_pkg::TIME_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ats_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [ats_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           q_valid,
    output logic                           q_pop,
    input  logic [1:0]                     q_cmd,
    input  logic [TW-1:0]                  q_time,
    output logic                           res_valid,
    input  logic                           res_ready,
    output ats_pkg::result_t               res
);
    localparam int OW = ats_pkg::OCC_W;
    localparam int RW = ats_pkg::RATIO_W;
    localparam int CW = ats_pkg::CNT_W;
    localparam int TOT_W = RW + 1;
    localparam int PW = OW + 7;
    // fill percent above a limit means count*100 at or above (limit+1)*depth
    localparam logic [PW-1:0] FILL_ON  = PW'((EP + 1) * QD);
    localparam logic [PW-1:0] FILL_OFF = PW'((XP + 1) * QD);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_WAIT = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [RW-1:0] ns_reg, nd_reg, ps_reg, pd_reg, thr_reg;
    logic [ats_pkg::CFG_DATA_W-1:0] win_reg, quiet_reg;

    logic [31:0]   seed_reg, seed_next;
    logic [OW-1:0] qc_reg, qc_next;
    logic fill_reg, fill_next, dsig_reg, dsig_next, mode_reg, mode_next;
    logic [CW-1:0] drops_reg, drops_next, daw_reg, daw_next, rej_reg, rej_next;
    logic [TW-1:0] wb_reg, wb_next, lhd_reg, lhd_next;
    logic [63:0]   prod_reg, prod_next;
    logic [TOT_W-1:0] rem_reg, rem_next, tot_reg, tot_next;
    logic [RW-1:0] sn_reg, sn_next;
    logic [5:0]    bit_reg, bit_next;
    logic adm_reg, adm_next, enq_reg, enq_next, deq_reg, deq_next;
    logic outv_reg, outv_next;
    ats_pkg::result_t res_reg, res_next;

    logic [TOT_W-1:0] tot_c;
    logic [RW-1:0]    sn_c;
    logic [TOT_W:0]   trial;
    logic [PW-1:0]    fprod;
    logic [TW-1:0]    dwin, dq, wlen, qlen;
    logic [CW-1:0]    fresh;
    logic fill_c, dsig_c;

    assign q_pop     = (state_reg == ST_IDLE) && q_valid && !outv_reg;
    assign res_valid = outv_reg;
    assign res       = res_reg;

    assign wlen = TW'(win_reg);
    assign qlen = TW'(quiet_reg);

    always_comb
    begin
        sn_c  = mode_reg ? ps_reg : ns_reg;
        tot_c = mode_reg ? ({1'b0, ps_reg} + {1'b0, pd_reg})
                         : ({1'b0, ns_reg} + {1'b0, nd_reg});
        trial = {rem_reg, prod_reg[31 - bit_reg[4:0]]} - {1'b0, tot_reg};
        fprod = PW'(qc_reg) * PW'(100);
        dwin  = q_time - wb_reg;
        fresh = drops_reg - daw_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        seed_next = seed_reg; qc_next = qc_reg;
        fill_next = fill_reg; dsig_next = dsig_reg; mode_next = mode_reg;
        drops_next = drops_reg; daw_next = daw_reg; rej_next = rej_reg;
        wb_next = wb_reg; lhd_next = lhd_reg;
        prod_next = prod_reg; rem_next = rem_reg; tot_next = tot_reg;
        sn_next = sn_reg; bit_next = bit_reg;
        adm_next = adm_reg; enq_next = enq_reg; deq_next = deq_reg;
        outv_next = outv_reg && !res_ready;
        res_next = res_reg;
        fill_c = fill_reg; dsig_c = dsig_reg; dq = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    adm_next = 1'b0; enq_next = 1'b0; deq_next = 1'b0;
                    state_next = ST_OUT;
                    unique case (ats_pkg::cmd_t'(q_cmd))
                        ats_pkg::CMD_SAMPLE:
                        begin
                            if (tot_c == '0)
                                rej_next = rej_reg + 1'b1;
                            else
                            begin
                                tot_next = tot_c;
                                sn_next = sn_c;
                                prod_next = seed_reg * ats_pkg::LCG_MUL;
                                state_next = ST_MUL;
                            end
                        end
                        ats_pkg::CMD_ENQUEUE:
                        begin
                            if (qc_reg >= OW'(QD))
                                drops_next = drops_reg + 1'b1;
                            else
                            begin
                                qc_next = qc_reg + 1'b1;
                                enq_next = 1'b1;
                            end
                        end
                        ats_pkg::CMD_DEQUEUE:
                        begin
                            if (qc_reg != '0)
                            begin
                                qc_next = qc_reg - 1'b1;
                                deq_next = 1'b1;
                            end
                        end
                        ats_pkg::CMD_UPDATE:
                        begin
                            fill_c = fill_reg ? (fprod >= FILL_OFF) : (fprod >= FILL_ON);
                            if (dwin >= wlen)
                            begin
                                daw_next = drops_reg;
                                wb_next = q_time;
                                if (fresh >= CW'(thr_reg))
                                begin
                                    dsig_c = 1'b1;
                                    lhd_next = q_time;
                                end
                            end
                            dq = q_time - (dsig_c && !dsig_reg ? q_time : lhd_reg);
                            if (dwin >= wlen && fresh >= CW'(thr_reg))
                                dq = '0;
                            if (dsig_c && dq >= qlen)
                                dsig_c = 1'b0;
                            fill_next = fill_c;
                            dsig_next = dsig_c;
                            mode_next = fill_c || dsig_c;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL:
            begin
                seed_next = prod_reg[31:0] + ats_pkg::LCG_ADD;
                prod_next = {32'd0, prod_reg[31:0] + ats_pkg::LCG_ADD};
                rem_next = '0;
                bit_next = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // restoring remainder, one seed bit per cycle
                if (!trial[TOT_W])
                    rem_next = trial[TOT_W-1:0];
                else
                    rem_next = {rem_reg[TOT_W-2:0], prod_reg[31 - bit_reg[4:0]]};
                bit_next = bit_reg + 1'b1;
                if (bit_reg == 6'd31)
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                adm_next = (rem_reg < {1'b0, sn_reg});
                if (rem_reg >= {1'b0, sn_reg})
                    rej_next = rej_reg + 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                outv_next = 1'b1;
                res_next.admitted = adm_reg;
                res_next.enqueued = enq_reg;
                res_next.dequeued = deq_reg;
                res_next.pressure_mode = mode_reg;
                res_next.fill_flag = fill_reg;
                res_next.drop_flag = dsig_reg;
                res_next.occupancy = qc_reg;
                res_next.drop_total = drops_reg;
                res_next.rejected_total = rej_reg;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ns_reg <= RW'(1); nd_reg <= '0; ps_reg <= RW'(1); pd_reg <= RW'(9);
            thr_reg <= RW'(5);
            win_reg <= 48'd1000000000; quiet_reg <= 48'd3000000000;
            seed_reg <= ats_pkg::SEED_RST; qc_reg <= '0;
            fill_reg <= 1'b0; dsig_reg <= 1'b0; mode_reg <= 1'b0;
            drops_reg <= '0; daw_reg <= '0; rej_reg <= '0;
            wb_reg <= '0; lhd_reg <= '0;
            outv_reg <= 1'b0;
            adm_reg <= 1'b0; enq_reg <= 1'b0; deq_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            seed_reg <= seed_next; qc_reg <= qc_next;
            fill_reg <= fill_next; dsig_reg <= dsig_next; mode_reg <= mode_next;
            drops_reg <= drops_next; daw_reg <= daw_next; rej_reg <= rej_next;
            wb_reg <= wb_next; lhd_reg <= lhd_next;
            outv_reg <= outv_next;
            adm_reg <= adm_next; enq_reg <= enq_next; deq_reg <= deq_next;
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    ats_pkg::REG_NORMAL_SAMPLE:   ns_reg <= cfg_data[RW-1:0];
                    ats_pkg::REG_NORMAL_DROP:     nd_reg <= cfg_data[RW-1:0];
                    ats_pkg::REG_PRESSURE_SAMPLE: ps_reg <= cfg_data[RW-1:0];
                    ats_pkg::REG_PRESSURE_DROP:   pd_reg <= cfg_data[RW-1:0];
                    ats_pkg::REG_DROP_THRESHOLD:  thr_reg <= cfg_data[RW-1:0];
                    ats_pkg::REG_DROP_WINDOW:     win_reg <= cfg_data;
                    ats_pkg::REG_QUIET_CLEAR:     quiet_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next; rem_reg <= rem_next; tot_reg <= tot_next;
        sn_reg <= sn_next; bit_reg <= bit_next; res_reg <= res_next;
    end
endmodule

// ===== design/adaptive_trace_sampler_unit.sv =====
// top level of the adaptive trace sampler
// usage: events arrive on the req channel (cmd, now_time) as valid/ready
// requests and each produces exactly one result on the rsp channel.
// configuration is a plain write port (cfg_we, cfg_idx, cfg_data); the user
// must see that it is written only while the block is idle, which the block
// itself does not enforce; unknown indexes are ignored. a two-entry queue in
// front takes requests while the back end works. enqueue, dequeue, update
// and zero-ratio sample requests go from the queue straight to the output
// state; a sample request does the 32x32 multiply at the pop, then passes the
// MUL state (seed update), the DIV state (remainder of the 32-bit generator
// value, one bit per cycle) and the WAIT state (compare) before the output.
// the back end takes the next event only after the previous result is taken.
// reset clears all counters, flags, the generator seed (12345) and the
// config registers to their defaults.
// when the receiver stalls the result is held; the back end stops and the
// front queue fills, then req ready drops.
module adaptive_trace_sampler_unit #(
    parameter int SLOT_COUNT  = ats_pkg::SLOT_COUNT_DEF,
    parameter int ENTER_PCT   = ats_pkg::ENTER_PCT_DEF,
    parameter int EXIT_PCT    = ats_pkg::EXIT_PCT_DEF,
    parameter int TIME_WIDTH  = ats_pkg::TIME_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ats_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [ats_pkg::CFG_DATA_W-1:0] cfg_data,
    ats_stream_if.sink                     req,
    ats_stream_if.source                   rsp
);
    logic                  q_valid, q_pop;
    logic [1:0]            q_cmd;
    logic [TIME_WIDTH-1:0] q_time;
    ats_pkg::result_t      res;

    ats_front #(.TW(TIME_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(req.valid), .in_ready(req.ready),
        .in_cmd(req.data[1:0]), .in_time(req.data[TIME_WIDTH+1:2]),
        .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd), .q_time(q_time)
    );

    ats_back #(.QD(SLOT_COUNT), .EP(ENTER_PCT), .XP(EXIT_PCT), .TW(TIME_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd), .q_time(q_time),
        .res_valid(rsp.valid), .res_ready(rsp.ready), .res(res)
    );

    assign rsp.data = res;
endmodule

// ===== design/ats_checker.sv =====
// port-level checks for the adaptive trace sampler
module ats_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [80:0] rsp_data
);
    // admitted, enqueued, dequeued are mutually exclusive
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $onehot0(rsp_data[80:78])) else $error("outcome bits clash");
    // pressure mode is fill or drop
    a_mode: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data[77] == (rsp_data[76] | rsp_data[75])))
        else $error("mode mismatch");
    // occupancy never exceeds the default depth of 1024
    a_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data[74:64] <= 11'd1024)) else $error("occupancy range");
    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data)) else $error("unstable");
endmodule

bind adaptive_trace_sampler_unit ats_checker u_ats_checker (
    .clk(clk), .rst_n(rst_n),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

// ===== tb/sv/tb.sv =====
// self-checking testbench for the adaptive trace sampler unit
module tb;

    localparam int REQ_W = 2 + ats_pkg::TIME_WIDTH_DEF;
    localparam int RSP_W = $bits(ats_pkg::result_t);
    localparam logic [2:0] IDX_UNUSED = 3'd7;
    localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [ats_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [ats_pkg::CFG_DATA_W-1:0] cfg_data;

    ats_stream_if #(.W(REQ_W)) req_ch ();
    ats_stream_if #(.W(RSP_W)) rsp_ch ();

    adaptive_trace_sampler_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_idx(cfg_idx),
        .cfg_data(cfg_data),
        .req(req_ch.sink),
        .rsp(rsp_ch.source)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // shadow of the block's configuration and state
    logic [15:0] m_norm_s, m_norm_d, m_pres_s, m_pres_d, m_thresh;
    logic [47:0] m_win_len, m_quiet_len;
    logic [31:0] m_seed;
    logic [10:0] m_occ;
    logic m_fill, m_drop, m_mode;
    logic [31:0] m_drops, m_drops_win, m_rejects;
    logic [47:0] m_win_begin, m_last_heavy;

    ats_pkg::result_t expected_results[$];
    int errors = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_cycles = 0;
    logic [47:0] cur_time = 48'd0;
    logic [47:0] time_step = 48'd400000000;

    function automatic ats_pkg::result_t trace_predict(ats_pkg::cmd_t c, logic [47:0] now);
        ats_pkg::result_t r;
        logic [16:0] tot;
        logic [15:0] share;
        int unsigned fpct;
        r = '0;
        case (c)
            ats_pkg::CMD_SAMPLE:
            begin
                share = m_mode ? m_pres_s : m_norm_s;
                tot = m_mode ? ({1'b0, m_pres_s} + m_pres_d) : ({1'b0, m_norm_s} + m_norm_d);
                if (tot != 0)
                begin
                    m_seed = m_seed * ats_pkg::LCG_MUL + ats_pkg::LCG_ADD;
                    r.admitted = ((m_seed % {15'd0, tot}) < {16'd0, share});
                end
                if (!r.admitted)
                    m_rejects = m_rejects + 1;
            end
            ats_pkg::CMD_ENQUEUE:
            begin
                if (m_occ >= ats_pkg::SLOT_COUNT_DEF)
                    m_drops = m_drops + 1;
                else
                begin
                    m_occ = m_occ + 11'd1;
                    r.enqueued = 1'b1;
                end
            end
            ats_pkg::CMD_DEQUEUE:
            begin
                if (m_occ > 0)
                begin
                    m_occ = m_occ - 11'd1;
                    r.dequeued = 1'b1;
                end
            end
            default:
            begin
                fpct = (m_occ * 100) / ats_pkg::SLOT_COUNT_DEF;
                m_fill = m_fill ? (fpct > ats_pkg::EXIT_PCT_DEF) : (fpct > ats_pkg::ENTER_PCT_DEF);
                if (now - m_win_begin >= m_win_len)
                begin
                    if (m_drops - m_drops_win >= {16'd0, m_thresh})
                    begin
                        m_last_heavy = now;
                        m_drop = 1'b1;
                    end
                    m_drops_win = m_drops;
                    m_win_begin = now;
                end
                if (m_drop && (now - m_last_heavy >= m_quiet_len))
                    m_drop = 1'b0;
                m_mode = m_fill | m_drop;
            end
        endcase
        r.pressure_mode = m_mode;
        r.fill_flag = m_fill;
        r.drop_flag = m_drop;
        r.occupancy = m_occ;
        r.drop_total = m_drops;
        r.rejected_total = m_rejects;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t mismatch %s expected %0h actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        ats_pkg::result_t got, want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = ats_pkg::result_t'(rsp_ch.data);
            if (expected_results.size() == 0)
            begin
                $display("%0t unexpected result %0h", $time, got);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("admitted", want.admitted, got.admitted);
                check_field("enqueued", want.enqueued, got.enqueued);
                check_field("dequeued", want.dequeued, got.dequeued);
                check_field("pressure_mode", want.pressure_mode, got.pressure_mode);
                check_field("fill_flag", want.fill_flag, got.fill_flag);
                check_field("drop_flag", want.drop_flag, got.drop_flag);
                check_field("occupancy", want.occupancy, got.occupancy);
                check_field("drop_total", want.drop_total, got.drop_total);
                check_field("rejected_total", want.rejected_total, got.rejected_total);
            end
        end
    end

    // receiver: random stalls plus an optional long hold-off
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_request(ats_pkg::cmd_t c, logic [47:0] now, bit typed,
                                ats_pkg::result_t typed_r);
        ats_pkg::result_t p;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= {now, c};
        do
            @(posedge clk);
        while (!req_ch.ready);
        p = trace_predict(c, now);
        expected_results.push_back(typed ? typed_r : p);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [47:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            ats_pkg::REG_NORMAL_SAMPLE:   m_norm_s = val[15:0];
            ats_pkg::REG_NORMAL_DROP:     m_norm_d = val[15:0];
            ats_pkg::REG_PRESSURE_SAMPLE: m_pres_s = val[15:0];
            ats_pkg::REG_PRESSURE_DROP:   m_pres_d = val[15:0];
            ats_pkg::REG_DROP_THRESHOLD:  m_thresh = val[15:0];
            ats_pkg::REG_DROP_WINDOW:     m_win_len = val;
            ats_pkg::REG_QUIET_CLEAR:     m_quiet_len = val;
            default: ;
        endcase
    endtask

    task automatic set_config(logic [15:0] ns, logic [15:0] nd, logic [15:0] ps,
                              logic [15:0] pd, logic [15:0] th, logic [47:0] wl,
                              logic [47:0] ql);
        drain_results();
        write_reg(ats_pkg::REG_NORMAL_SAMPLE, {32'hFFFF_A5A5, ns});
        write_reg(ats_pkg::REG_NORMAL_DROP, {32'h5A5A_0000, nd});
        write_reg(ats_pkg::REG_PRESSURE_SAMPLE, {32'd0, ps});
        write_reg(ats_pkg::REG_PRESSURE_DROP, {32'hFFFF_FFFF, pd});
        write_reg(ats_pkg::REG_DROP_THRESHOLD, {32'd0, th});
        write_reg(ats_pkg::REG_DROP_WINDOW, wl);
        write_reg(ats_pkg::REG_QUIET_CLEAR, ql);
        write_reg(IDX_UNUSED, TIME_MAX);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [47:0] next_time();
        int unsigned pick;
        pick = $urandom_range(19);
        if (pick == 0)
            cur_time = 48'({$urandom, $urandom});
        else if (pick == 1)
            cur_time = cur_time - 48'($urandom_range(1000));
        else if (pick == 2)
            cur_time = cur_time;
        else
            cur_time = cur_time + 48'({$urandom, $urandom} % 64'(time_step + 48'd1));
        return cur_time;
    endfunction

    // weights in percent: sample, enqueue, dequeue, rest update
    task automatic random_items(int count, int w_smp, int w_enq, int w_deq);
        int unsigned r;
        ats_pkg::cmd_t c;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < w_smp)
                c = ats_pkg::CMD_SAMPLE;
            else if (r < w_smp + w_enq)
                c = ats_pkg::CMD_ENQUEUE;
            else if (r < w_smp + w_enq + w_deq)
                c = ats_pkg::CMD_DEQUEUE;
            else
                c = ats_pkg::CMD_UPDATE;
            send_request(c, (c == ats_pkg::CMD_UPDATE) ? next_time()
                                                      : 48'({$urandom, $urandom}),
                         1'b0, '0);
        end
    endtask

    task automatic set_idling(int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 77; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 77; end
            default: begin send_idle_pct = 29; stall_pct = 29; end
        endcase
    endtask

    typedef struct {
        ats_pkg::cmd_t    c;
        logic [47:0]      now;
        bit               typed;
        ats_pkg::result_t r;
    } stim_row_t;

    stim_row_t directed_rows[$];

    initial
    begin
        ats_pkg::result_t z;
        z = '0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        m_norm_s = 16'd1; m_norm_d = 16'd0; m_pres_s = 16'd1; m_pres_d = 16'd9;
        m_thresh = 16'd5; m_win_len = 48'd1000000000; m_quiet_len = 48'd3000000000;
        m_seed = ats_pkg::SEED_RST; m_occ = '0; m_fill = 0; m_drop = 0; m_mode = 0;
        m_drops = 0; m_drops_win = 0; m_rejects = 0; m_win_begin = 0; m_last_heavy = 0;

        // dequeue on empty, update at zero time, enqueue, dequeue, always-admit sample,
        // update at max time
        directed_rows.push_back('{ats_pkg::CMD_DEQUEUE, 48'd0, 1'b1, z});
        directed_rows.push_back('{ats_pkg::CMD_UPDATE, 48'd0, 1'b1, z});
        directed_rows.push_back('{ats_pkg::CMD_ENQUEUE, TIME_MAX, 1'b1,
                                  '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                                    11'd1, 32'd0, 32'd0}});
        directed_rows.push_back('{ats_pkg::CMD_DEQUEUE, 48'd0, 1'b1,
                                  '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                                    11'd0, 32'd0, 32'd0}});
        directed_rows.push_back('{ats_pkg::CMD_SAMPLE, TIME_MAX, 1'b1,
                                  '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                    11'd0, 32'd0, 32'd0}});
        directed_rows.push_back('{ats_pkg::CMD_UPDATE, TIME_MAX, 1'b1, z});
        // time going backwards, then samples, enqueues, a dequeue and a couple of updates
        directed_rows.push_back('{ats_pkg::CMD_UPDATE, 48'd5, 1'b0, z});
        directed_rows.push_back('{ats_pkg::CMD_SAMPLE, 48'd0, 1'b0, z});
        directed_rows.push_back('{ats_pkg::CMD_ENQUEUE, 48'd0, 1'b0, z});
        directed_rows.push_back('{ats_pkg::CMD_ENQUEUE, 48'd0, 1'b0, z});
        directed_rows.push_back('{ats_pkg::CMD_UPDATE, 48'h8000_0000_0000, 1'b0, z});
        directed_rows.push_back('{ats_pkg::CMD_SAMPLE, 48'h5555_5555_5555, 1'b0, z});
        directed_rows.push_back('{ats_pkg::CMD_DEQUEUE, 48'hAAAA_AAAA_AAAA, 1'b0, z});
        directed_rows.push_back('{ats_pkg::CMD_UPDATE, 48'h8000_3B9A_CA00, 1'b0, z});

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].c, directed_rows[i].now, directed_rows[i].typed,
                         directed_rows[i].r);

        // zero ratio total in both modes, zero threshold, shortest lengths
        set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 48'd1, 48'd1);
        directed_rows.delete();
        for (int i = 0; i < 4; i++)
            send_request(ats_pkg::CMD_SAMPLE, 48'd0, 1'b0, z);
        send_request(ats_pkg::CMD_UPDATE, 48'd100, 1'b0, z);
        send_request(ats_pkg::CMD_SAMPLE, 48'd0, 1'b0, z);
        send_request(ats_pkg::CMD_UPDATE, 48'd101, 1'b0, z);
        send_request(ats_pkg::CMD_UPDATE, 48'd103, 1'b0, z);

        // random phases across settings and idling modes
        set_idling(0);
        set_config(16'd1, 16'd0, 16'd1, 16'd9, 16'd5, 48'd1000000000, 48'd3000000000);
        time_step = 48'd400000000;
        random_items(30, 25, 30, 25);

        set_idling(1);
        set_config(16'd65535, 16'd65535, 16'd0, 16'd65535, 16'd0, 48'd50, 48'd200);
        time_step = 48'd60;
        random_items(30, 30, 25, 20);

        // fill the queue past full and watch drops and the fill signal
        set_idling(2);
        set_config(16'd3, 16'd7, 16'd65535, 16'd0, 16'd2, 48'd1000, 48'd4000);
        time_step = 48'd700;
        random_items(1030, 0, 99, 0);

        // long receiver hold-off while requests keep coming
        hold_cycles = 400;
        random_items(20, 0, 50, 0);

        set_idling(3);
        set_config(16'd1, 16'd1, 16'd1, 16'd3, 16'd65535, TIME_MAX, TIME_MAX);
        time_step = 48'hFFFF_FFFF;
        random_items(30, 20, 5, 55);

        // sender pause until everything has come back
        drain_results();

        set_idling(0);
        set_config(16'd65535, 16'd0, 16'd40000, 16'd30000, 16'd1, 48'd20, 48'd1);
        time_step = 48'd30;
        random_items(30, 25, 25, 25);

        set_idling(2);
        set_config(16'd0, 16'd65535, 16'd65535, 16'd65535, 16'd3, 48'd100, 48'd1000);
        time_step = 48'd120;
        random_items(30, 30, 20, 30);

        set_idling(1);
        random_items(30, 10, 10, 70);

        set_idling(3);
        set_config(16'd12345, 16'd54321, 16'd7, 16'd1, 16'd4, 48'd500, 48'd3000);
        time_step = 48'd300;
        random_items(30, 25, 30, 25);

        drain_results();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #60000000;
        $display("FAIL");
        $finish;
    end

endmodule
